// ===== design/lzwd_pkg.sv =====
package lzwd_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(12'hFEE);
    localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WIN_DEPTH - 1);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // decode phase codes
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_BYTE = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    localparam logic [4:0] MIN_MATCH = 5'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_COPY
    } lzwd_state_t;

endpackage

// ===== design/lzss_window_decoder.sv =====
// channel   | signals                                   | request
// ----------+-------------------------------------------+---------------------------------
// input     | in_valid, in_stall, in_byte               | one compressed byte
// output    | out_valid, out_stall, out_byte,           | one decoded byte
//           | last_of_run, length_reached               |
// config    | output_length_we, output_length           | write of the output length limit
//
// flag bytes, reference low bytes and literals are taken one per cycle while the output
// register can take a new byte; a reference's high byte starts a copy of 3 to 18 bytes
// through the single read port of the window memory, one copied byte per cycle on the same
// condition; overlapping copies are forwarded; after reset a clearing pass zeroes all 4096
// window entries and no input is taken meanwhile; the output register holds a stalled
// request; input stalls while a copy runs or the output register cannot take a new byte
module lzss_window_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        output_length_we,
    input  logic [31:0] output_length,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        length_reached
);

    logic [7:0] win_mem [lzwd_pkg::WIN_DEPTH];

    lzwd_pkg::lzwd_state_t state_reg, state_next;

    logic [lzwd_pkg::WIN_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [lzwd_pkg::WIN_AW-1:0] wp_reg, wp_next;
    logic [lzwd_pkg::WIN_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [8:0]                  flag_reg, flag_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [7:0]                  ref_low_reg, ref_low_next;
    logic [31:0]                 count_reg, count_next;
    logic [31:0]                 olen_reg, olen_next;
    logic                        stopped_reg, stopped_next;
    logic [4:0]                  rem_reg, rem_next;
    logic                        fwd_reg, fwd_next;
    logic [7:0]                  fwd_data_reg, fwd_data_next;
    logic [7:0]                  rdata_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        last_reg, last_next;
    logic                        reached_reg, reached_next;

    logic                        mem_we;
    logic [lzwd_pkg::WIN_AW-1:0] mem_waddr;
    logic [7:0]                  mem_wdata;
    logic [lzwd_pkg::WIN_AW-1:0] mem_raddr;

    logic [7:0]                  copy_data;
    logic [31:0]                 count_inc;
    logic                        slot_free;
    logic [8:0]                  flag_shr;
    logic [1:0]                  phase_after;
    logic [lzwd_pkg::WIN_AW-1:0] rd_ptr_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= win_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwd_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            wp_reg        <= lzwd_pkg::START_POS;
            flag_reg      <= '0;
            phase_reg     <= lzwd_pkg::PH_FLAG;
            ref_low_reg   <= '0;
            count_reg     <= '0;
            olen_reg      <= '0;
            stopped_reg   <= 1'b0;
            rem_reg       <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            wp_reg        <= wp_next;
            flag_reg      <= flag_next;
            phase_reg     <= phase_next;
            ref_low_reg   <= ref_low_next;
            count_reg     <= count_next;
            olen_reg      <= olen_next;
            stopped_reg   <= stopped_next;
            rem_reg       <= rem_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg   <= rd_ptr_next;
        fwd_data_reg <= fwd_data_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        reached_reg  <= reached_next;
    end

    assign copy_data   = fwd_reg ? fwd_data_reg : rdata_reg;
    assign count_inc   = (count_reg == lzwd_pkg::COUNT_MAX) ? count_reg : count_reg + 32'd1;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign flag_shr    = {1'b0, flag_reg[8:1]};
    assign phase_after = (flag_shr[8:1] == '0) ? lzwd_pkg::PH_FLAG : lzwd_pkg::PH_BYTE;
    assign rd_ptr_inc  = rd_ptr_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        wp_next        = wp_reg;
        rd_ptr_next    = rd_ptr_reg;
        flag_next      = flag_reg;
        phase_next     = phase_reg;
        ref_low_next   = ref_low_reg;
        count_next     = count_reg;
        olen_next      = output_length_we ? output_length : olen_reg;
        stopped_next   = stopped_reg;
        rem_next       = rem_reg;
        fwd_next       = 1'b0;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        reached_next   = reached_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = in_byte;
        mem_raddr      = rd_ptr_reg;
        in_stall       = 1'b1;

        unique case (state_reg)
            lzwd_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == lzwd_pkg::WIN_LAST)
                begin
                    state_next = lzwd_pkg::ST_RUN;
                end
            end

            lzwd_pkg::ST_RUN:
            begin
                in_stall = !slot_free;
                if (in_valid && slot_free)
                begin
                    if (stopped_reg || (count_reg >= olen_reg))
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        case (phase_reg)
                            lzwd_pkg::PH_BYTE:
                            begin
                                if (flag_reg[8:1] == '0)
                                begin
                                    flag_next  = {1'b1, in_byte};
                                    phase_next = lzwd_pkg::PH_BYTE;
                                end
                                else if (flag_reg[0])
                                begin
                                    // literal
                                    mem_we         = 1'b1;
                                    wp_next        = wp_reg + 1'b1;
                                    count_next     = count_inc;
                                    out_valid_next = 1'b1;
                                    out_byte_next  = in_byte;
                                    last_next      = 1'b1;
                                    reached_next   = count_inc >= olen_reg;
                                    flag_next      = flag_shr;
                                    phase_next     = phase_after;
                                end
                                else
                                begin
                                    ref_low_next = in_byte;
                                    phase_next   = lzwd_pkg::PH_HIGH;
                                end
                            end

                            lzwd_pkg::PH_HIGH:
                            begin
                                mem_raddr   = {in_byte[7:4], ref_low_reg};
                                rd_ptr_next = {in_byte[7:4], ref_low_reg};
                                rem_next    = {1'b0, in_byte[3:0]} + lzwd_pkg::MIN_MATCH;
                                state_next  = lzwd_pkg::ST_COPY;
                            end

                            default:
                            begin
                                flag_next  = {1'b1, in_byte};
                                phase_next = lzwd_pkg::PH_BYTE;
                            end
                        endcase
                    end
                end
            end

            lzwd_pkg::ST_COPY:
            begin
                if (slot_free)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = copy_data;
                    wp_next        = wp_reg + 1'b1;
                    count_next     = count_inc;
                    out_valid_next = 1'b1;
                    out_byte_next  = copy_data;
                    last_next      = rem_reg == 5'd1;
                    reached_next   = count_inc >= olen_reg;
                    rd_ptr_next    = rd_ptr_inc;
                    mem_raddr      = rd_ptr_inc;
                    // read of the entry written in this same cycle
                    fwd_next       = rd_ptr_inc == wp_reg;
                    fwd_data_next  = copy_data;
                    rem_next       = rem_reg - 5'd1;
                    if (rem_reg == 5'd1)
                    begin
                        flag_next  = flag_shr;
                        phase_next = phase_after;
                        state_next = lzwd_pkg::ST_RUN;
                    end
                end
            end

            default:
            begin
                state_next = lzwd_pkg::ST_RUN;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_run    = last_reg;
    assign length_reached = reached_reg;

endmodule

// ===== design/lzwd_checker.sv =====
module lzwd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       length_reached
);

    // stalled output request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run)
            && $stable(length_reached))
        else $error("stalled output request changed");

    // a copy run keeps one byte per cycle once the output moves
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("copy run broke off");

    // no input taken in the middle of a copy run
    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("input accepted during copy run");

    // window clearing follows reset
    a_clear_after_reset: assert property (@(posedge clk)
        !rst_n |=> in_stall)
        else $error("input not stalled right after reset");

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .length_reached (length_reached)
);

// ===== test/tb_lzss_window_decoder.sv =====
module tb_lzss_window_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;

    typedef logic [lzwd_pkg::WIN_AW-1:0] win_addr_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       reached;
    } dec_byte_t;

    logic        clk;
    logic        rst_n;
    logic        output_length_we;
    logic [31:0] output_length;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        length_reached;

    // decoder state as predicted
    logic [7:0]                  hist [lzwd_pkg::WIN_DEPTH];
    logic [lzwd_pkg::WIN_AW-1:0] wr_pos;
    logic [8:0]                  flag_bits;
    logic [1:0]                  phase;
    logic [7:0]                  ref_lo;
    logic [31:0]                 n_out;
    logic                        halted;
    logic [31:0]                 out_limit;

    dec_byte_t expected_bytes [$];

    int  errors;
    int  cycles;
    int  bytes_sent;
    int  bytes_checked;
    int  stall_left;
    bit  steady;

    lzss_window_decoder u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .output_length_we (output_length_we),
        .output_length    (output_length),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .last_of_run      (last_of_run),
        .length_reached   (length_reached)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, what, want, got);
        errors++;
    endtask

    task automatic emit_byte(input logic [7:0] c, input logic last);
        dec_byte_t e;
        hist[wr_pos] = c;
        wr_pos = wr_pos + 1'b1;
        if (n_out != lzwd_pkg::COUNT_MAX)
            n_out = n_out + 1;
        e.data = c;
        e.last = last;
        e.reached = (n_out >= out_limit);
        expected_bytes.push_back(e);
    endtask

    task automatic advance_flags();
        flag_bits = flag_bits >> 1;
        phase = (flag_bits <= 9'd1) ? lzwd_pkg::PH_FLAG : lzwd_pkg::PH_BYTE;
    endtask

    task automatic decode_in_byte(input logic [7:0] b);
        logic [lzwd_pkg::WIN_AW-1:0] src;
        int len;
        int i;
        if (halted || n_out >= out_limit)
        begin
            halted = 1'b1;
            return;
        end
        if (phase == lzwd_pkg::PH_BYTE && flag_bits > 9'd1)
        begin
            if (flag_bits[0])
            begin
                emit_byte(b, 1'b1);
                advance_flags();
            end
            else
            begin
                ref_lo = b;
                phase = lzwd_pkg::PH_HIGH;
            end
        end
        else if (phase == lzwd_pkg::PH_HIGH)
        begin
            src = {b[7:4], ref_lo};
            len = int'(b[3:0]) + 3;
            for (i = 0; i < len; i++)
            begin
                emit_byte(hist[src], i == len - 1);
                src = src + 1'b1;
            end
            advance_flags();
        end
        else
        begin
            flag_bits = {1'b1, b};
            phase = lzwd_pkg::PH_BYTE;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        decode_in_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_output_length(input logic [31:0] v);
        wait_drain();
        output_length_we <= 1'b1;
        output_length    <= v;
        out_limit = v;
        @(negedge clk);
        output_length_we <= 1'b0;
    endtask

    task automatic send_reference(input logic [lzwd_pkg::WIN_AW-1:0] pos,
                                  input logic [3:0] len_code);
        send_byte(pos[7:0]);
        send_byte({pos[11:8], len_code});
    endtask

    task automatic send_random_groups(input int n_items);
        logic [7:0]                  flags_b;
        logic [lzwd_pkg::WIN_AW-1:0] src;
        int sent;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 7))
                0: flags_b = 8'h00;
                1: flags_b = 8'hFF;
                default: flags_b = 8'($urandom);
            endcase
            send_byte(flags_b);
            sent++;
            for (k = 0; k < 8 && sent < n_items; k++)
            begin
                // occasional stray byte knocks the stream out of alignment
                if ($urandom_range(0, 19) == 0)
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
                else if (flags_b[k])
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
                else
                begin
                    if ($urandom_range(0, 2) != 0)
                        src = wr_pos - win_addr_t'($urandom_range(1, 40));
                    else
                        src = win_addr_t'($urandom);
                    send_reference(src, 4'($urandom));
                    sent += 2;
                end
            end
        end
    endtask

    task automatic test_literals();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
    endtask

    task automatic test_references();
        send_byte(8'hF0);
        send_reference(lzwd_pkg::START_POS, 4'h0);
        // overlaps the bytes it writes and wraps the window
        send_reference(12'hFF4, 4'hF);
        // reads back bytes that the wrapping copy above wrote
        send_reference(12'h000, 4'h0);
        send_reference(lzwd_pkg::WIN_LAST, 4'hF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'hC3);
        send_byte(8'h3C);
    endtask

    task automatic test_random_stream();
        send_random_groups(100);
        set_output_length(n_out + 32'd100000);
        steady = 1'b1;
        send_random_groups(40);
        steady = 1'b0;
        send_random_groups(60);
    endtask

    task automatic test_length_limit();
        set_output_length(n_out + 32'd7);
        send_byte(8'h00);
        send_reference(wr_pos - 12'd5, 4'hF);
        send_byte(8'h3A);
        send_byte(8'hFF);
        send_byte(8'h00);
        set_output_length(32'd0);
        send_byte(8'hFF);
        send_byte(8'h41);
        // limit raised again, decoding stays stopped
        set_output_length(lzwd_pkg::COUNT_MAX);
        send_byte(8'hFF);
        send_byte(8'h42);
        wait_drain();
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0 && rst_n)
            stall_left = pick_gap();
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        dec_byte_t e;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("unexpected request, out_byte", 8'h00, out_byte);
            else
            begin
                e = expected_bytes.pop_front();
                if (out_byte !== e.data)
                    report_mismatch("out_byte", e.data, out_byte);
                if (last_of_run !== e.last)
                    report_mismatch("last_of_run", 8'(e.last), 8'(last_of_run));
                if (length_reached !== e.reached)
                    report_mismatch("length_reached", 8'(e.reached), 8'(length_reached));
                bytes_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        output_length_we = 1'b0;
        output_length = '0;
        in_valid = 1'b0;
        in_byte = '0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        bytes_sent = 0;
        bytes_checked = 0;
        stall_left = 0;
        steady = 1'b0;
        foreach (hist[i])
            hist[i] = 8'h00;
        wr_pos = lzwd_pkg::START_POS;
        flag_bits = '0;
        phase = lzwd_pkg::PH_FLAG;
        ref_lo = '0;
        n_out = '0;
        halted = 1'b0;
        out_limit = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_output_length(lzwd_pkg::COUNT_MAX);
        test_literals();
        test_references();
        test_random_stream();
        test_length_limit();

        $display("sent %0d compressed bytes, checked %0d decoded bytes", bytes_sent,
                 bytes_checked);
        $display("covered literals, overlapping and wrapping copies, and the length stop");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/lzwd_pkg.sv
design/lzss_window_decoder.sv
design/lzwd_checker.sv
test/tb_lzss_window_decoder.sv
